@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and reset.
`define ASSERT_CLK_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Assertion on the project clock and reset names.
`define ASSERT_STD(label, prop) \
   `ASSERT_CLK_RST(label, clock, reset, prop)

`endif

@@ rtl/core/dmsc_pkg.sv @@
// ----------------------------------------------------------------------------
// dmsc_pkg
// Shared widths, register indexes and control types of the speed controller.
// ----------------------------------------------------------------------------
package dmsc_pkg;

   localparam int MOTOR_COUNT = 2;
   localparam int DATA_W      = 16;
   localparam int MUL_W       = DATA_W + 2;
   localparam int PROD_W      = 2 * MUL_W;
   localparam int ACC_W       = 40;
   localparam int CSR_IDX_W   = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SETPOINT_A   = 3'd0,
      REG_SETPOINT_B   = 3'd1,
      REG_PROP_GAIN_A  = 3'd2,
      REG_INTEG_GAIN_A = 3'd3,
      REG_PROP_GAIN_B  = 3'd4,
      REG_INTEG_GAIN_B = 3'd5,
      REG_RPM_SCALE    = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] setpoint_a;
      logic signed [DATA_W-1:0] setpoint_b;
      logic        [DATA_W-1:0] prop_gain_a;
      logic        [DATA_W-1:0] integ_gain_a;
      logic        [DATA_W-1:0] prop_gain_b;
      logic        [DATA_W-1:0] integ_gain_b;
      logic        [DATA_W-1:0] rpm_scale;
   } cfg_type;

   // Controls of the shared multiply-accumulate unit.
   typedef struct packed {
      logic mul_en;     // register a*b
      logic acc_load;   // accumulator <= base
      logic acc_add;    // accumulator += product
      logic add_shift;  // product scaled by 16 before the add
   } mac_ctrl_type;

endpackage

@@ rtl/core/dual_motor_encoder_pi_speed_control.sv @@
// ----------------------------------------------------------------------------
// dual_motor_encoder_pi_speed_control
// Incremental PI speed controller for two encoder-fed motors.
//
// Each request carries one motor's raw quadrature count for a sample tick.
// The block derives position (65535 - count), the signed pulse delta from
// that motor's previous position, speed = delta * rpm_scale (Q8.8, truncated
// toward zero, saturated), error = setpoint - speed, and the incremental PI
// update u = u_last + kp*(e - e_last) + ki_t*e with kp Q4.12, ki_t Q0.16,
// truncated toward zero once and saturated to int16. A response gives the
// motor, PWM duty min(|u|,255), a forward bit (u > 0), u and the speed.
// Requests are taken one at a time: a new one is accepted only once the
// previous response has been registered. The sequencer drives one shared
// 18x18 multiplier through its three products (speed scale, proportional,
// integral) with saturation steps in between. req_stall is high while an
// item is in flight, and a response held by rsp_stall delays the finishing
// step. A motor index at or beyond the motor count is dropped without a
// response or state change.
// ----------------------------------------------------------------------------
module dual_motor_encoder_pi_speed_control (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_motor,
   input  logic [dmsc_pkg::DATA_W-1:0]         req_encoder_count,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_motor_id,
   output logic [7:0]                          rsp_pwm_duty,
   output logic                                rsp_forward,
   output logic signed [dmsc_pkg::DATA_W-1:0]  rsp_control_value,
   output logic signed [dmsc_pkg::DATA_W-1:0]  rsp_speed_rpm,
   // configuration write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dmsc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dmsc_pkg::DATA_W-1:0]         csr_data
);
   import dmsc_pkg::*;

   localparam logic [1:0] MotorCount = 2'(MOTOR_COUNT);

   typedef enum logic [2:0] {
      ST_IDLE,      // wait for a request
      ST_SPD_MUL,   // delta * rpm_scale
      ST_SPD_SAT,   // speed: truncate by 256, saturate
      ST_ERR,       // error, accumulator <= u_last << 16
      ST_P_MUL,     // kp * (e - e_last)
      ST_I_MUL,     // acc += 16*P; ki * e
      ST_I_ACC,     // acc += I
      ST_FINISH     // u: truncate by 65536, saturate; respond
   } state_type;

   cfg_type                  cfg;
   mac_ctrl_type             mac_ctrl;
   logic signed [MUL_W-1:0]  mac_a;
   logic signed [MUL_W-1:0]  mac_b;
   logic signed [ACC_W-1:0]  mac_base;
   logic signed [PROD_W-1:0] mac_prod;
   logic signed [ACC_W-1:0]  mac_acc;

   // sequencer and working registers
   state_type                state_ff, state_in;
   logic                     motor_ff, motor_in;
   logic [DATA_W-1:0]        pulses_ff, pulses_in;
   logic signed [DATA_W-1:0] speed_ff, speed_in;
   logic signed [DATA_W-1:0] err_ff, err_in;

   // per-motor state
   logic [DATA_W-1:0]        last_pos_ff [MOTOR_COUNT];
   logic [DATA_W-1:0]        last_pos_in [MOTOR_COUNT];
   logic signed [DATA_W-1:0] last_err_ff [MOTOR_COUNT];
   logic signed [DATA_W-1:0] last_err_in [MOTOR_COUNT];
   logic signed [DATA_W-1:0] last_ctl_ff [MOTOR_COUNT];
   logic signed [DATA_W-1:0] last_ctl_in [MOTOR_COUNT];

   // response registers
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_motor_ff, rsp_motor_in;
   logic [7:0]               rsp_duty_ff, rsp_duty_in;
   logic                     rsp_fwd_ff, rsp_fwd_in;
   logic signed [DATA_W-1:0] rsp_ctl_ff, rsp_ctl_in;
   logic signed [DATA_W-1:0] rsp_speed_ff, rsp_speed_in;

   // datapath
   logic                     accept;
   logic                     motor_ok;
   logic                     out_free;
   logic [DATA_W-1:0]        position;
   logic signed [DATA_W-1:0] setp_sel;
   logic [DATA_W-1:0]        kp_sel;
   logic [DATA_W-1:0]        ki_sel;
   logic signed [PROD_W-1:0] spd_bias;
   logic signed [PROD_W-9:0] spd_q;
   logic signed [DATA_W-1:0] spd_sat;
   logic signed [DATA_W:0]   err_diff;
   logic signed [DATA_W-1:0] err_sat;
   logic signed [DATA_W:0]   derr;
   logic signed [ACC_W-1:0]  u_bias;
   logic signed [ACC_W-17:0] u_q;
   logic signed [DATA_W-1:0] u_sat;
   logic [DATA_W:0]          u_mag;
   logic [7:0]               u_duty;

   dmsc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   dmsc_mac u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .base  (mac_base),
      .prod  (mac_prod),
      .acc   (mac_acc)
   );

   assign req_stall         = (state_ff != ST_IDLE);
   assign accept            = req_valid && !req_stall;
   assign motor_ok          = ({1'b0, req_motor} < MotorCount);
   assign out_free          = !rsp_valid_ff || !rsp_stall;
   assign position          = ~req_encoder_count;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_motor_id      = rsp_motor_ff;
   assign rsp_pwm_duty      = rsp_duty_ff;
   assign rsp_forward       = rsp_fwd_ff;
   assign rsp_control_value = rsp_ctl_ff;
   assign rsp_speed_rpm     = rsp_speed_ff;

   // per-motor configuration
   always_comb begin
      if (motor_ff) begin
         setp_sel = cfg.setpoint_b;
         kp_sel   = cfg.prop_gain_b;
         ki_sel   = cfg.integ_gain_b;
      end else begin
         setp_sel = cfg.setpoint_a;
         kp_sel   = cfg.prop_gain_a;
         ki_sel   = cfg.integ_gain_a;
      end
   end

   // saturation and rounding arithmetic
   always_comb begin
      // speed = trunc0(prod / 256), saturated
      spd_bias = mac_prod + (mac_prod[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
      spd_q    = spd_bias[PROD_W-1:8];
      if (spd_q > (PROD_W-8)'(32767)) begin
         spd_sat = 16'sh7FFF;
      end else if (spd_q < -(PROD_W-8)'(32768)) begin
         spd_sat = -16'sh8000;
      end else begin
         spd_sat = spd_q[DATA_W-1:0];
      end

      err_diff = {setp_sel[DATA_W-1], setp_sel} - {speed_ff[DATA_W-1], speed_ff};
      if (err_diff[DATA_W] != err_diff[DATA_W-1]) begin
         err_sat = err_diff[DATA_W] ? -16'sh8000 : 16'sh7FFF;
      end else begin
         err_sat = err_diff[DATA_W-1:0];
      end

      derr = {err_ff[DATA_W-1], err_ff}
           - {last_err_ff[motor_ff][DATA_W-1], last_err_ff[motor_ff]};

      // u = trunc0(acc / 65536), saturated
      u_bias = mac_acc + (mac_acc[ACC_W-1] ? ACC_W'(65535) : ACC_W'(0));
      u_q    = u_bias[ACC_W-1:16];
      if (u_q > (ACC_W-16)'(32767)) begin
         u_sat = 16'sh7FFF;
      end else if (u_q < -(ACC_W-16)'(32768)) begin
         u_sat = -16'sh8000;
      end else begin
         u_sat = u_q[DATA_W-1:0];
      end

      u_mag  = u_sat[DATA_W-1] ? ((DATA_W+1)'(0) - {u_sat[DATA_W-1], u_sat})
                               : {1'b0, u_sat};
      u_duty = (u_mag > (DATA_W+1)'(255)) ? 8'hFF : u_mag[7:0];
   end

   // shared unit operands
   always_comb begin
      mac_ctrl = '0;
      mac_a    = '0;
      mac_b    = '0;
      mac_base = {{(ACC_W-DATA_W-16){last_ctl_ff[motor_ff][DATA_W-1]}},
                  last_ctl_ff[motor_ff], 16'h0000};
      case (state_ff)
         ST_SPD_MUL: begin
            mac_ctrl.mul_en = 1'b1;
            mac_a = {{(MUL_W-DATA_W){pulses_ff[DATA_W-1]}}, pulses_ff};
            mac_b = {{(MUL_W-DATA_W){1'b0}}, cfg.rpm_scale};
         end
         ST_ERR: begin
            mac_ctrl.acc_load = 1'b1;
         end
         ST_P_MUL: begin
            mac_ctrl.mul_en = 1'b1;
            mac_a = {{(MUL_W-DATA_W-1){derr[DATA_W]}}, derr};
            mac_b = {{(MUL_W-DATA_W){1'b0}}, kp_sel};
         end
         ST_I_MUL: begin
            mac_ctrl.acc_add   = 1'b1;
            mac_ctrl.add_shift = 1'b1;
            mac_ctrl.mul_en    = 1'b1;
            mac_a = {{(MUL_W-DATA_W){err_ff[DATA_W-1]}}, err_ff};
            mac_b = {{(MUL_W-DATA_W){1'b0}}, ki_sel};
         end
         ST_I_ACC: begin
            mac_ctrl.acc_add = 1'b1;
         end
         default: begin
            mac_ctrl = '0;
         end
      endcase
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      motor_in     = motor_ff;
      pulses_in    = pulses_ff;
      speed_in     = speed_ff;
      err_in       = err_ff;
      last_pos_in  = last_pos_ff;
      last_err_in  = last_err_ff;
      last_ctl_in  = last_ctl_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_motor_in = rsp_motor_ff;
      rsp_duty_in  = rsp_duty_ff;
      rsp_fwd_in   = rsp_fwd_ff;
      rsp_ctl_in   = rsp_ctl_ff;
      rsp_speed_in = rsp_speed_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && motor_ok) begin
               motor_in               = req_motor;
               pulses_in              = position - last_pos_ff[req_motor];
               last_pos_in[req_motor] = position;
               state_in               = ST_SPD_MUL;
            end
         end
         ST_SPD_MUL: state_in = ST_SPD_SAT;
         ST_SPD_SAT: begin
            speed_in = spd_sat;
            state_in = ST_ERR;
         end
         ST_ERR: begin
            err_in   = err_sat;
            state_in = ST_P_MUL;
         end
         ST_P_MUL:   state_in = ST_I_MUL;
         ST_I_MUL:   state_in = ST_I_ACC;
         ST_I_ACC:   state_in = ST_FINISH;
         ST_FINISH: begin
            // hold here while the previous response is stalled
            if (out_free) begin
               last_err_in[motor_ff] = err_ff;
               last_ctl_in[motor_ff] = u_sat;
               rsp_valid_in          = 1'b1;
               rsp_motor_in          = motor_ff;
               rsp_duty_in           = u_duty;
               rsp_fwd_in            = !u_sat[DATA_W-1] && (u_sat != '0);
               rsp_ctl_in            = u_sat;
               rsp_speed_in          = speed_ff;
               state_in              = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         last_pos_ff  <= '{default: '0};
         last_err_ff  <= '{default: '0};
         last_ctl_ff  <= '{default: '0};
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         last_pos_ff  <= last_pos_in;
         last_err_ff  <= last_err_in;
         last_ctl_ff  <= last_ctl_in;
      end
      motor_ff     <= motor_in;
      pulses_ff    <= pulses_in;
      speed_ff     <= speed_in;
      err_ff       <= err_in;
      rsp_motor_ff <= rsp_motor_in;
      rsp_duty_ff  <= rsp_duty_in;
      rsp_fwd_ff   <= rsp_fwd_in;
      rsp_ctl_ff   <= rsp_ctl_in;
      rsp_speed_ff <= rsp_speed_in;
   end

endmodule

@@ rtl/core/dmsc_csr.sv @@
// ----------------------------------------------------------------------------
// dmsc_csr
// Configuration register file: setpoints, gains and rpm scale.
// ----------------------------------------------------------------------------
module dmsc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [dmsc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dmsc_pkg::DATA_W-1:0]      csr_data,
   output dmsc_pkg::cfg_type                cfg
);
   import dmsc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            REG_SETPOINT_A:   cfg_in.setpoint_a   = csr_data;
            REG_SETPOINT_B:   cfg_in.setpoint_b   = csr_data;
            REG_PROP_GAIN_A:  cfg_in.prop_gain_a  = csr_data;
            REG_INTEG_GAIN_A: cfg_in.integ_gain_a = csr_data;
            REG_PROP_GAIN_B:  cfg_in.prop_gain_b  = csr_data;
            REG_INTEG_GAIN_B: cfg_in.integ_gain_b = csr_data;
            REG_RPM_SCALE:    cfg_in.rpm_scale    = csr_data;
            default:          cfg_in = cfg_ff;   // unmapped index: ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setpoint_a   <= -16'sd100;
         cfg_ff.setpoint_b   <= 16'sd120;
         cfg_ff.prop_gain_a  <= 16'd3686;
         cfg_ff.integ_gain_a <= 16'd8847;
         cfg_ff.prop_gain_b  <= 16'd3686;
         cfg_ff.integ_gain_b <= 16'd10158;
         cfg_ff.rpm_scale    <= 16'd1164;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/core/dmsc_mac.sv @@
// ----------------------------------------------------------------------------
// dmsc_mac
// Shared signed multiplier with registered product and accumulator.
// ----------------------------------------------------------------------------
module dmsc_mac (
   input  logic                                  clock,
   input  dmsc_pkg::mac_ctrl_type                ctrl,
   input  logic signed [dmsc_pkg::MUL_W-1:0]     op_a,
   input  logic signed [dmsc_pkg::MUL_W-1:0]     op_b,
   input  logic signed [dmsc_pkg::ACC_W-1:0]     base,
   output logic signed [dmsc_pkg::PROD_W-1:0]    prod,
   output logic signed [dmsc_pkg::ACC_W-1:0]     acc
);
   import dmsc_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  prod_ext;

   assign prod = prod_ff;
   assign acc  = acc_ff;

   always_comb begin
      prod_in  = prod_ff;
      if (ctrl.mul_en) begin
         prod_in = op_a * op_b;
      end
      prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      if (ctrl.add_shift) begin
         prod_ext = prod_ext <<< 4;
      end
      acc_in = acc_ff;
      if (ctrl.acc_load) begin
         acc_in = base;
      end else if (ctrl.acc_add) begin
         acc_in = acc_ff + prod_ext;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

endmodule

@@ rtl/core/dmsc_checker.sv @@
// ----------------------------------------------------------------------------
// dmsc_checker
// Port-level assertions for the speed controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dmsc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [7:0]                          rsp_pwm_duty,
   input logic                                rsp_forward,
   input logic signed [dmsc_pkg::DATA_W-1:0]  rsp_control_value
);

   logic       ctl_pos;    // control value above zero
   logic [7:0] duty_pos;   // clamped magnitude of a non-negative control value

   assign ctl_pos  = !rsp_control_value[15] && (rsp_control_value != 16'sd0);
   assign duty_pos = (rsp_control_value[14:8] != 7'd0) ? 8'hFF : rsp_control_value[7:0];

   // stalled response holds
   `ASSERT_STD(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_control_value))

   // one request in flight: busy right after acceptance
   `ASSERT_STD(a_busy_after_req, req_valid && !req_stall |=> req_stall)

   // direction bit matches sign of control value
   `ASSERT_STD(a_forward, rsp_valid |-> (rsp_forward == ctl_pos))

   // duty is the clamped magnitude for non-negative control values
   `ASSERT_STD(a_duty, rsp_valid && !rsp_control_value[15] |-> rsp_pwm_duty == duty_pos)

endmodule

bind dual_motor_encoder_pi_speed_control dmsc_checker u_dmsc_checker (.*);

@@ tb/sv/dual_motor_encoder_pi_speed_control_checker.sv @@
// ----------------------------------------------------------------------------
// dual_motor_encoder_pi_speed_control_checker
// Watches the request, response and register channels of the speed controller,
// predicts every response from its own copy of the controller state and
// settings, and compares each accepted response with the oldest prediction.
// ----------------------------------------------------------------------------
module dual_motor_encoder_pi_speed_control_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic                                req_motor,
   input  logic [dmsc_pkg::DATA_W-1:0]         req_encoder_count,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic                                rsp_motor_id,
   input  logic [7:0]                          rsp_pwm_duty,
   input  logic                                rsp_forward,
   input  logic signed [dmsc_pkg::DATA_W-1:0]  rsp_control_value,
   input  logic signed [dmsc_pkg::DATA_W-1:0]  rsp_speed_rpm,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [dmsc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dmsc_pkg::DATA_W-1:0]         csr_data,
   output int                                  pending,
   output int                                  errors
);
   import dmsc_pkg::*;

   typedef struct packed {
      logic                     motor;
      logic [7:0]               duty;
      logic                     fwd;
      logic signed [DATA_W-1:0] ctl;
      logic signed [DATA_W-1:0] spd;
   } pwm_cmd_type;

   cfg_type                  cfg;
   logic [DATA_W-1:0]        last_pos [MOTOR_COUNT];
   logic signed [DATA_W-1:0] last_err [MOTOR_COUNT];
   logic signed [DATA_W-1:0] last_ctl [MOTOR_COUNT];
   pwm_cmd_type              pwm_cmd_q [$];
   int                       mismatches = 0;

   function automatic longint clamp16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // One controller tick: speed from pulse delta, then incremental PI update.
   function automatic pwm_cmd_type pi_update(logic m, logic [DATA_W-1:0] count);
      logic [DATA_W-1:0] pos;
      logic [DATA_W-1:0] delta;
      longint            pulses, spd, setp, kp, ki, err, u, acc, mag;
      pwm_cmd_type       r;
      pos         = 16'hFFFF - count;
      delta       = pos - last_pos[m];
      last_pos[m] = pos;
      pulses      = longint'($signed(delta));
      spd         = clamp16(pulses * longint'(cfg.rpm_scale) / 256);
      if (m == 1'b0) begin
         setp = longint'(cfg.setpoint_a);
         kp   = longint'(cfg.prop_gain_a);
         ki   = longint'(cfg.integ_gain_a);
      end else begin
         setp = longint'(cfg.setpoint_b);
         kp   = longint'(cfg.prop_gain_b);
         ki   = longint'(cfg.integ_gain_b);
      end
      err = clamp16(setp - spd);
      // exact sum, truncated toward zero once
      acc = longint'(last_ctl[m]) * 65536
          + kp * (err - longint'(last_err[m])) * 16
          + ki * err;
      u   = clamp16(acc / 65536);
      last_err[m] = err[DATA_W-1:0];
      last_ctl[m] = u[DATA_W-1:0];
      mag = (u < 0) ? -u : u;
      if (mag > 255) mag = 255;
      r.motor = m;
      r.duty  = mag[7:0];
      r.fwd   = (u > 0);
      r.ctl   = u[DATA_W-1:0];
      r.spd   = spd[DATA_W-1:0];
      return r;
   endfunction

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      pwm_cmd_type want;
      if (reset) begin
         cfg.setpoint_a   = -16'sd100;
         cfg.setpoint_b   = 16'sd120;
         cfg.prop_gain_a  = 16'd3686;
         cfg.integ_gain_a = 16'd8847;
         cfg.prop_gain_b  = 16'd3686;
         cfg.integ_gain_b = 16'd10158;
         cfg.rpm_scale    = 16'd1164;
         for (int i = 0; i < MOTOR_COUNT; i++) begin
            last_pos[i] = '0;
            last_err[i] = '0;
            last_ctl[i] = '0;
         end
         pwm_cmd_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               REG_SETPOINT_A:   cfg.setpoint_a   = csr_data;
               REG_SETPOINT_B:   cfg.setpoint_b   = csr_data;
               REG_PROP_GAIN_A:  cfg.prop_gain_a  = csr_data;
               REG_INTEG_GAIN_A: cfg.integ_gain_a = csr_data;
               REG_PROP_GAIN_B:  cfg.prop_gain_b  = csr_data;
               REG_INTEG_GAIN_B: cfg.integ_gain_b = csr_data;
               REG_RPM_SCALE:    cfg.rpm_scale    = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            pwm_cmd_q.push_back(pi_update(req_motor, req_encoder_count));
         if (rsp_valid && !rsp_stall) begin
            if (pwm_cmd_q.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected response, motor %0d control %0d, nothing expected",
                        $time, rsp_motor_id, rsp_control_value);
            end else begin
               want = pwm_cmd_q.pop_front();
               check_field("motor_id", want.motor, rsp_motor_id);
               check_field("pwm_duty", want.duty, rsp_pwm_duty);
               check_field("forward", want.fwd, rsp_forward);
               check_field("control_value", want.ctl, rsp_control_value);
               check_field("speed_rpm", want.spd, rsp_speed_rpm);
            end
         end
      end
      pending <= pwm_cmd_q.size();
      errors  <= mismatches;
   end

endmodule

@@ tb/sv/dual_motor_encoder_pi_speed_control_test.sv @@
// ----------------------------------------------------------------------------
// dual_motor_encoder_pi_speed_control_test
// Top of the speed controller testbench. Drives encoder tick requests and
// register writes with random gaps and response stalls; the checker beside
// the block predicts and compares, and this module gives the verdict.
// ----------------------------------------------------------------------------
module dual_motor_encoder_pi_speed_control_test;
   import dmsc_pkg::*;

   // index past the end of the register map; a write there must be ignored
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;
   localparam int STALL_LIMIT  = 3000;   // cycles with no handshake at all
   localparam int DRAIN_CYCLES = 12;     // extra idle wait after the last predicted response
   localparam int RANDOM_PHASES = 13;

   logic                      clock;
   logic                      reset             = 1'b1;
   logic                      req_valid         = 1'b0;
   logic                      req_stall;
   logic                      req_motor         = 1'b0;
   logic [DATA_W-1:0]         req_encoder_count = '0;
   logic                      rsp_valid;
   logic                      rsp_stall         = 1'b0;
   logic                      rsp_motor_id;
   logic [7:0]                rsp_pwm_duty;
   logic                      rsp_forward;
   logic signed [DATA_W-1:0]  rsp_control_value;
   logic signed [DATA_W-1:0]  rsp_speed_rpm;
   logic                      csr_valid         = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index         = '0;
   logic [DATA_W-1:0]         csr_data          = '0;

   int   pending;
   int   errors;

   // stimulus bookkeeping
   bit                steady = 1'b0;     // no gaps on either side while set
   int                span   = 100;      // typical encoder movement per tick
   logic [DATA_W-1:0] enc_pos [MOTOR_COUNT] = '{default: '0};
   int                n_ticks    = 0;
   int                n_writes   = 0;
   int                n_settings = 0;

   dual_motor_encoder_pi_speed_control u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_motor         (req_motor),
      .req_encoder_count (req_encoder_count),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_motor_id      (rsp_motor_id),
      .rsp_pwm_duty      (rsp_pwm_duty),
      .rsp_forward       (rsp_forward),
      .rsp_control_value (rsp_control_value),
      .rsp_speed_rpm     (rsp_speed_rpm),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   dual_motor_encoder_pi_speed_control_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_motor         (req_motor),
      .req_encoder_count (req_encoder_count),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_motor_id      (rsp_motor_id),
      .rsp_pwm_duty      (rsp_pwm_duty),
      .rsp_forward       (rsp_forward),
      .rsp_control_value (rsp_control_value),
      .rsp_speed_rpm     (rsp_speed_rpm),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .pending           (pending),
      .errors            (errors)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Gap length shared by sender and receiver: mostly none or short,
   // now and then a long one. Steady phases run back to back.
   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(20, 60);
   endfunction

   // Next encoder reading for a motor. Most ticks move the counter by a
   // bounded step (a turning shaft, wrapping through zero); some jump
   // anywhere or stand still.
   function automatic logic [DATA_W-1:0] encoder_sample(logic m);
      int r;
      r = $urandom_range(0, 99);
      if (r < 80)
         enc_pos[m] = enc_pos[m] + DATA_W'($urandom_range(0, 2 * span) - span);
      else if (r < 92)
         enc_pos[m] = DATA_W'($urandom_range(0, 65535));
      return enc_pos[m];
   endfunction

   // Register value: corners often, typical operating values otherwise.
   function automatic logic [DATA_W-1:0] pick_setting(bit is_signed);
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return is_signed ? 16'h8000 : 16'h0001;
         3:       return 16'h7FFF;
         4, 5:    return is_signed ? DATA_W'($urandom_range(0, 600) - 300)
                                   : DATA_W'($urandom_range(0, 12000));
         default: return DATA_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // Request side: optional gap, then hold the request until it is taken.
   task automatic send_tick(input logic m, input logic [DATA_W-1:0] count);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_motor         <= m;
      req_encoder_count <= count;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      n_ticks++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      n_writes++;
      @(posedge clock);
   endtask

   // Stop sending and wait until every predicted response has come back,
   // then DRAIN_CYCLES more, so register writes land on an idle block.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Response side: random stall bursts between runs of readiness.
   initial begin
      int n;
      @(posedge clock);
      forever begin
         n = pick_gap();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   end

   // Watchdog: ends the run when no channel moves for too long.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
             || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("watchdog: no handshake for %0d cycles, %0d responses outstanding",
               STALL_LIMIT, pending);
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      int n_items;
      bit is_signed;
      logic m;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed: reset settings, counter extremes on both motors ---
      // first tick from zero history: 65535 - 0 against last position 0
      send_tick(1'b0, 16'h0000);
      send_tick(1'b1, 16'h0000);
      send_tick(1'b0, 16'hFFFF);
      send_tick(1'b1, 16'hFFFF);
      send_tick(1'b0, 16'h7FFF);     // largest negative pulse delta
      send_tick(1'b1, 16'h8000);
      send_tick(1'b0, 16'h0000);
      send_tick(1'b1, 16'h0001);
      drain();
      n_settings++;

      // --- directed: every register at its extreme, speed saturates ---
      write_reg(REG_RPM_SCALE,    16'hFFFF);
      write_reg(REG_SETPOINT_A,   16'h7FFF);
      write_reg(REG_SETPOINT_B,   16'h8000);
      write_reg(REG_PROP_GAIN_A,  16'hFFFF);
      write_reg(REG_INTEG_GAIN_A, 16'hFFFF);
      write_reg(REG_PROP_GAIN_B,  16'hFFFF);
      write_reg(REG_INTEG_GAIN_B, 16'hFFFF);
      // index past the map: must not disturb any setting
      write_reg(REG_UNUSED, 16'h0000);
      send_tick(1'b0, 16'h8000);
      send_tick(1'b1, 16'h0000);
      send_tick(1'b0, 16'h0000);
      send_tick(1'b1, 16'h8000);
      send_tick(1'b0, 16'h8000);     // control value driven into both rails
      send_tick(1'b1, 16'h8000);
      send_tick(1'b0, 16'h7FFF);
      send_tick(1'b1, 16'h7FFE);
      drain();
      n_settings++;

      // --- directed: zero gains and zero scale, control value held at its last value ---
      write_reg(REG_RPM_SCALE,    16'h0000);
      write_reg(REG_SETPOINT_A,   16'h0000);
      write_reg(REG_PROP_GAIN_A,  16'h0000);
      write_reg(REG_INTEG_GAIN_A, 16'h0000);
      write_reg(REG_PROP_GAIN_B,  16'h0000);
      write_reg(REG_INTEG_GAIN_B, 16'h0000);
      send_tick(1'b0, 16'h1234);
      send_tick(1'b1, 16'hFEDC);
      send_tick(1'b0, 16'h4321);
      send_tick(1'b1, 16'h0F0F);
      drain();
      n_settings++;

      // --- random phases: new settings on an idle block, then a tick stream ---
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         for (int r = REG_SETPOINT_A; r <= REG_RPM_SCALE; r++) begin
            is_signed = (r == REG_SETPOINT_A) || (r == REG_SETPOINT_B);
            if ($urandom_range(0, 9) < 7)
               write_reg(r[CSR_IDX_W-1:0], pick_setting(is_signed));
         end
         if ($urandom_range(0, 3) == 0)
            write_reg(REG_UNUSED, DATA_W'($urandom_range(0, 65535)));
         n_settings++;

         steady = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 3))
            0:       span = 8;
            1:       span = 100;
            2:       span = 1000;
            default: span = 32767;
         endcase

         n_items = $urandom_range(80, 120);
         for (int i = 0; i < n_items; i++) begin
            // mostly alternate motors like a timer interrupt would, sometimes not
            m = ($urandom_range(0, 4) == 0) ? 1'($urandom_range(0, 1)) : 1'(i % 2);
            send_tick(m, encoder_sample(m));
         end
         steady = 1'b0;
         drain();
      end

      $display("Summary: %0d encoder ticks on both motors under %0d controller settings,",
               n_ticks, n_settings);
      $display("         %0d register writes incl. out-of-map index and gain/scale extremes",
               n_writes);
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
